// File: sv/assert_macros.svh
// Assertion macros used by the RTL.
// Each macro is a clocked concurrent assertion with a disable iff reset guard, or nothing under NO_ASSERTIONS.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// ante in a cycle implies cons in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// ante in a cycle implies cons in the following cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst, cond, msg)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// File: sv/irm_pkg.sv
`timescale 1ns / 1ps

package irm_pkg;

   // default table depths
   localparam int ADDR_ENTRIES_DEF  = 16;
   localparam int PORT_ENTRIES_DEF  = 16;
   localparam int PROTO_ENTRIES_DEF = 4;

   // stream widths
   localparam int REQ_DATA_W = 176;
   localparam int REQ_USER_W = 4;
   localparam int RSP_DATA_W = 48;
   localparam int RSP_USER_W = 2;

   // opcodes
   localparam logic [2:0] OP_CLEAR     = 3'd0;
   localparam logic [2:0] OP_ADD_ADDR  = 3'd1;
   localparam logic [2:0] OP_ADD_PORT  = 3'd2;
   localparam logic [2:0] OP_ADD_PROTO = 3'd3;
   localparam logic [2:0] OP_QUERY     = 3'd4;

   // result status
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_NOMATCH = 2'd2;

   // prefix limits per family
   localparam logic [7:0] V4_MAX_PFX = 8'd32;
   localparam logic [7:0] V6_MAX_PFX = 8'd128;

   // address table entry: address left-aligned in 128 bits
   typedef struct packed {
      logic         is_ipv6;
      logic [7:0]   prefix;
      logic [127:0] addr;
   } addr_entry_type;

   // port table entry
   typedef struct packed {
      logic [15:0] low;
      logic [15:0] high;
   } port_entry_type;

   // saturate a prefix to the family maximum
   function automatic logic [7:0] clamp_prefix(input logic [7:0] pfx, input logic v6);
      logic [7:0] lim;
      lim = v6 ? V6_MAX_PFX : V4_MAX_PFX;
      return (pfx > lim) ? lim : pfx;
   endfunction

   // left-align an address: IPv4 goes into the top 32 bits
   function automatic logic [127:0] align_addr(input logic [63:0] hi, input logic [63:0] lo,
                                               input logic v6);
      return v6 ? {hi, lo} : {lo[31:0], 96'd0};
   endfunction

endpackage

// File: sv/intercept_rule_matcher.sv
`timescale 1ns / 1ps

// Intercept rule matcher. Items arrive on the req_ stream: clear, add an address
// range, add a port range, add a protocol, or query. Every item returns exactly one
// transfer on the rsp_ stream. Address ranges and port ranges live in two table
// memories with a registered read; a query walks both tables together, one entry
// of each per cycle, and keeps the best (smallest prefix difference, narrowest port
// range) hit. The block works on one item at a time; its result register lets the
// next item in while the previous result still waits on rsp_tready. Reset or a
// clear item empties all tables at once.
module intercept_rule_matcher #(
   parameter int ADDR_ENTRIES  = irm_pkg::ADDR_ENTRIES_DEF,
   parameter int PORT_ENTRIES  = irm_pkg::PORT_ENTRIES_DEF,
   parameter int PROTO_ENTRIES = irm_pkg::PROTO_ENTRIES_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // address_high[63:0], address_low[127:64], prefix_length[135:128],
   // port_first[151:136], port_last[167:152], protocol_code[175:168]
   input  logic [irm_pkg::REQ_DATA_W-1:0]  req_tdata,
   // opcode[2:0], is_ipv6[3]
   input  logic [irm_pkg::REQ_USER_W-1:0]  req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // combined_score[23:0], address_score[31:24], port_score[47:32]
   output logic [irm_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // status[1:0]
   output logic [irm_pkg::RSP_USER_W-1:0]  rsp_tuser
);
   import irm_pkg::*;

`include "assert_macros.svh"

   localparam int A_CNT_W   = $clog2(ADDR_ENTRIES + 1);
   localparam int P_CNT_W   = $clog2(PORT_ENTRIES + 1);
   localparam int R_CNT_W   = $clog2(PROTO_ENTRIES + 1);
   localparam int A_IDX_W   = (ADDR_ENTRIES > 1) ? $clog2(ADDR_ENTRIES) : 1;
   localparam int P_IDX_W   = (PORT_ENTRIES > 1) ? $clog2(PORT_ENTRIES) : 1;
   localparam int R_IDX_W   = (PROTO_ENTRIES > 1) ? $clog2(PROTO_ENTRIES) : 1;
   localparam int MAX_ENTRIES = (ADDR_ENTRIES > PORT_ENTRIES) ? ADDR_ENTRIES : PORT_ENTRIES;
   localparam int SCAN_W    = $clog2(MAX_ENTRIES + 1);

   // sequencer states
   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_SCAN  = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_RESP  = 2'd3;

   // request fields
   logic [2:0]   req_opcode;
   logic         req_is_ipv6;
   logic [63:0]  req_address_high;
   logic [63:0]  req_address_low;
   logic [7:0]   req_prefix_length;
   logic [15:0]  req_port_first;
   logic [15:0]  req_port_last;
   logic [7:0]   req_protocol_code;

   assign req_opcode        = req_tuser[2:0];
   assign req_is_ipv6       = req_tuser[3];
   assign req_address_high  = req_tdata[63:0];
   assign req_address_low   = req_tdata[127:64];
   assign req_prefix_length = req_tdata[135:128];
   assign req_port_first    = req_tdata[151:136];
   assign req_port_last     = req_tdata[167:152];
   assign req_protocol_code = req_tdata[175:168];

   // control state
   logic [1:0]          state_ff, state_in;
   logic [A_CNT_W-1:0]  a_count_ff, a_count_in;
   logic [P_CNT_W-1:0]  p_count_ff, p_count_in;
   logic [R_CNT_W-1:0]  r_count_ff, r_count_in;
   logic [SCAN_W-1:0]   scan_ff, scan_in;
   logic                a_rd_vld_ff, a_rd_vld_in;
   logic                p_rd_vld_ff, p_rd_vld_in;
   logic                rsp_valid_ff, rsp_valid_in;

   // query and result payload
   logic [127:0]        q_addr_ff, q_addr_in;
   logic                q_v6_ff, q_v6_in;
   logic [7:0]          q_pfx_ff, q_pfx_in;
   logic [15:0]         q_port_ff, q_port_in;
   logic                q_proto_ok_ff, q_proto_ok_in;
   logic                q_is_query_ff, q_is_query_in;
   logic [1:0]          pend_status_ff, pend_status_in;
   logic                a_found_ff, a_found_in;
   logic [7:0]          a_best_ff, a_best_in;
   logic                p_found_ff, p_found_in;
   logic [15:0]         p_best_ff, p_best_in;
   logic [1:0]          rsp_status_ff, rsp_status_in;
   logic [7:0]          rsp_ascore_ff, rsp_ascore_in;
   logic [15:0]         rsp_pscore_ff, rsp_pscore_in;

   // protocol list: small register file compared in parallel
   logic [7:0]          proto_tab_ff [PROTO_ENTRIES];

   // table memories
   addr_entry_type      addr_mem [ADDR_ENTRIES];
   port_entry_type      port_mem [PORT_ENTRIES];
   addr_entry_type      addr_rdata_ff;
   port_entry_type      port_rdata_ff;
   logic                addr_we, port_we, proto_we;
   addr_entry_type      addr_wdata;
   port_entry_type      port_wdata;

   logic                accept;
   logic                issue_a, issue_p;
   logic                a_full, p_full, r_full;
   logic                proto_listed;
   logic [7:0]          req_pfx_clamped;
   logic                rsp_free;

   // address and port compares on the entries read last cycle
   logic [127:0]        a_mask;
   logic                a_hit;
   logic [7:0]          a_diff;
   logic                p_hit;
   logic [15:0]         p_width;

   assign accept     = req_tvalid && req_tready;
   assign req_tready = !reset && (state_ff == S_IDLE);
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign a_full = (a_count_ff == A_CNT_W'(ADDR_ENTRIES));
   assign p_full = (p_count_ff == P_CNT_W'(PORT_ENTRIES));
   assign r_full = (r_count_ff == R_CNT_W'(PROTO_ENTRIES));

   assign issue_a = (scan_ff < SCAN_W'(a_count_ff));
   assign issue_p = (scan_ff < SCAN_W'(p_count_ff));

   assign req_pfx_clamped = clamp_prefix(req_prefix_length, req_is_ipv6);

   // protocol membership over the loaded entries
   always_comb begin
      proto_listed = 1'b0;
      for (int i = 0; i < PROTO_ENTRIES; i++) begin
         if ((R_CNT_W'(i) < r_count_ff) && (proto_tab_ff[i] == req_protocol_code)) begin
            proto_listed = 1'b1;
         end
      end
   end

   // insert write data
   assign addr_we    = accept && (req_opcode == OP_ADD_ADDR) && !a_full;
   assign port_we    = accept && (req_opcode == OP_ADD_PORT) && !p_full;
   assign proto_we   = accept && (req_opcode == OP_ADD_PROTO) && !r_full;
   assign addr_wdata = '{is_ipv6: req_is_ipv6, prefix: req_pfx_clamped,
                          addr: align_addr(req_address_high, req_address_low, req_is_ipv6)};
   assign port_wdata = '{low: req_port_first, high: req_port_last};

   // address table memory
   always_ff @(posedge clock) begin
      if (addr_we) begin
         addr_mem[a_count_ff[A_IDX_W-1:0]] <= addr_wdata;
      end
      addr_rdata_ff <= addr_mem[scan_ff[A_IDX_W-1:0]];
   end

   // port table memory
   always_ff @(posedge clock) begin
      if (port_we) begin
         port_mem[p_count_ff[P_IDX_W-1:0]] <= port_wdata;
      end
      port_rdata_ff <= port_mem[scan_ff[P_IDX_W-1:0]];
   end

   // protocol list
   always_ff @(posedge clock) begin
      if (proto_we) begin
         proto_tab_ff[r_count_ff[R_IDX_W-1:0]] <= req_protocol_code;
      end
   end

   // per-entry compares
   assign a_mask  = ~({128{1'b1}} >> addr_rdata_ff.prefix);
   assign a_hit   = (addr_rdata_ff.is_ipv6 == q_v6_ff) && (q_pfx_ff >= addr_rdata_ff.prefix) &&
                    (((q_addr_ff ^ addr_rdata_ff.addr) & a_mask) == '0);
   assign a_diff  = q_pfx_ff - addr_rdata_ff.prefix;
   assign p_hit   = (port_rdata_ff.low <= q_port_ff) && (q_port_ff <= port_rdata_ff.high);
   assign p_width = port_rdata_ff.high - port_rdata_ff.low;

   // sequencer
   always_comb begin
      state_in       = state_ff;
      a_count_in     = a_count_ff;
      p_count_in     = p_count_ff;
      r_count_in     = r_count_ff;
      scan_in        = scan_ff;
      a_rd_vld_in    = 1'b0;
      p_rd_vld_in    = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_tready;
      q_addr_in      = q_addr_ff;
      q_v6_in        = q_v6_ff;
      q_pfx_in       = q_pfx_ff;
      q_port_in      = q_port_ff;
      q_proto_ok_in  = q_proto_ok_ff;
      q_is_query_in  = q_is_query_ff;
      pend_status_in = pend_status_ff;
      a_found_in     = a_found_ff;
      a_best_in      = a_best_ff;
      p_found_in     = p_found_ff;
      p_best_in      = p_best_ff;
      rsp_status_in  = rsp_status_ff;
      rsp_ascore_in  = rsp_ascore_ff;
      rsp_pscore_in  = rsp_pscore_ff;

      // fold in the entries read last cycle
      if (a_rd_vld_ff && a_hit && (!a_found_ff || (a_diff < a_best_ff))) begin
         a_found_in = 1'b1;
         a_best_in  = a_diff;
      end
      if (p_rd_vld_ff && p_hit && (!p_found_ff || (p_width < p_best_ff))) begin
         p_found_in = 1'b1;
         p_best_in  = p_width;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               q_addr_in      = align_addr(req_address_high, req_address_low, req_is_ipv6);
               q_v6_in        = req_is_ipv6;
               q_pfx_in       = req_pfx_clamped;
               q_port_in      = req_port_first;
               q_proto_ok_in  = (req_protocol_code == 8'd0) || proto_listed;
               q_is_query_in  = (req_opcode == OP_QUERY);
               pend_status_in = ST_OK;
               a_found_in     = 1'b0;
               p_found_in     = 1'b0;
               scan_in        = '0;
               state_in       = S_RESP;
               unique case (req_opcode)
                  OP_CLEAR: begin
                     a_count_in = '0;
                     p_count_in = '0;
                     r_count_in = '0;
                  end
                  OP_ADD_ADDR: begin
                     if (a_full) pend_status_in = ST_FULL;
                     else a_count_in = A_CNT_W'(a_count_ff + 1'b1);
                  end
                  OP_ADD_PORT: begin
                     if (p_full) pend_status_in = ST_FULL;
                     else p_count_in = P_CNT_W'(p_count_ff + 1'b1);
                  end
                  OP_ADD_PROTO: begin
                     if (r_full) pend_status_in = ST_FULL;
                     else r_count_in = R_CNT_W'(r_count_ff + 1'b1);
                  end
                  OP_QUERY: begin
                     state_in = S_SCAN;
                  end
                  default: begin
                     pend_status_in = ST_OK;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // one read of each table per cycle
            a_rd_vld_in = issue_a;
            p_rd_vld_in = issue_p;
            if (issue_a || issue_p) begin
               scan_in = SCAN_W'(scan_ff + 1'b1);
            end else begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            // last reads already folded; a spare state before the result
            state_in = S_RESP;
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_ascore_in = '0;
               rsp_pscore_in = '0;
               if (q_is_query_ff) begin
                  if (q_proto_ok_ff && a_found_ff && p_found_ff) begin
                     rsp_status_in = ST_OK;
                     rsp_ascore_in = a_best_ff;
                     rsp_pscore_in = p_best_ff;
                  end else begin
                     rsp_status_in = ST_NOMATCH;
                  end
               end else begin
                  rsp_status_in = pend_status_ff;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         a_count_ff   <= '0;
         p_count_ff   <= '0;
         r_count_ff   <= '0;
         scan_ff      <= '0;
         a_rd_vld_ff  <= 1'b0;
         p_rd_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         a_count_ff   <= a_count_in;
         p_count_ff   <= p_count_in;
         r_count_ff   <= r_count_in;
         scan_ff      <= scan_in;
         a_rd_vld_ff  <= a_rd_vld_in;
         p_rd_vld_ff  <= p_rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      q_addr_ff      <= q_addr_in;
      q_v6_ff        <= q_v6_in;
      q_pfx_ff       <= q_pfx_in;
      q_port_ff      <= q_port_in;
      q_proto_ok_ff  <= q_proto_ok_in;
      q_is_query_ff  <= q_is_query_in;
      pend_status_ff <= pend_status_in;
      a_found_ff     <= a_found_in;
      a_best_ff      <= a_best_in;
      p_found_ff     <= p_found_in;
      p_best_ff      <= p_best_in;
      rsp_status_ff  <= rsp_status_in;
      rsp_ascore_ff  <= rsp_ascore_in;
      rsp_pscore_ff  <= rsp_pscore_in;
   end

   // result stream
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {rsp_pscore_ff, rsp_ascore_ff, rsp_ascore_ff, rsp_pscore_ff};

   // checks
   `ASSERT_ALWAYS(a_count_range, clock, reset, a_count_ff <= A_CNT_W'(ADDR_ENTRIES), "address count beyond depth")
   `ASSERT_NEXT(busy_after_accept, clock, reset, accept, state_ff != S_IDLE, "block idle right after a transfer")
   `ASSERT_IMPLIES(reads_in_scan, clock, reset, a_rd_vld_ff || p_rd_vld_ff, state_ff == S_SCAN || state_ff == S_DRAIN, "table read outside a query scan")
   `ASSERT_IMPLIES(score_zero_on_miss, clock, reset, rsp_valid_ff && (rsp_status_ff != ST_OK), rsp_tdata == '0, "nonzero score without a match")

endmodule

// File: tb/intercept_rule_matcher_tb.sv
`timescale 1ns / 1ps

module intercept_rule_matcher_tb;
   import irm_pkg::*;

   localparam int ADDR_DEPTH    = ADDR_ENTRIES_DEF;
   localparam int PORT_DEPTH    = PORT_ENTRIES_DEF;
   localparam int PROTO_DEPTH   = PROTO_ENTRIES_DEF;
   localparam int RANDOM_ITEMS  = 2000;
   localparam int QUIET_TAIL    = 300;
   localparam int SETTLE_CYCLES = 40;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int PRINT_CAP     = 40;

   // opcodes the block treats as no-ops
   localparam logic [2:0] OP_SPARE_A = 3'd5;
   localparam logic [2:0] OP_SPARE_B = 3'd6;
   localparam logic [2:0] OP_SPARE_C = 3'd7;

   typedef struct {
      logic [2:0]  opcode;
      logic        is_ipv6;
      logic [63:0] addr_hi;
      logic [63:0] addr_lo;
      logic [7:0]  pfx;
      logic [15:0] port_first;
      logic [15:0] port_last;
      logic [7:0]  proto;
   } rule_item_type;

   typedef struct {
      logic [1:0]  status;
      logic [23:0] combined;
      logic [7:0]  addr_score;
      logic [15:0] port_score;
   } match_result_type;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic [REQ_USER_W-1:0]  req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic [RSP_USER_W-1:0]  rsp_tuser;

   // rule tables as the block should hold them
   addr_entry_type addr_rules[ADDR_DEPTH];
   port_entry_type port_rules[PORT_DEPTH];
   logic [7:0]     proto_rules[PROTO_DEPTH];
   int             addr_used  = 0;
   int             port_used  = 0;
   int             proto_used = 0;

   match_result_type pending_results[$];

   bit gaps_on       = 1'b1;
   int stall_left    = 0;
   int cycle_count   = 0;
   int error_count   = 0;
   int items_sent    = 0;
   int queries_hit   = 0;
   int queries_miss  = 0;
   int full_inserts  = 0;

   intercept_rule_matcher u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results pending", cycle_count,
                  pending_results.size());
         $display("FAIL intercept_rule_matcher");
         $finish;
      end
   end

   // sized random values
   function automatic logic rand_flag();
      return 1'($urandom);
   endfunction

   function automatic logic [7:0] rand_byte();
      return 8'($urandom);
   endfunction

   function automatic logic [15:0] rand_half();
      return 16'($urandom);
   endfunction

   // mask with the top pfx bits of a 128-bit address set
   function automatic logic [127:0] prefix_mask(input logic [7:0] pfx);
      logic [127:0] ones;
      ones = ~128'd0;
      return ones << (128 - pfx);
   endfunction

   // expected result of one item; updates the rule tables
   function automatic match_result_type predict_match(input rule_item_type it);
      match_result_type res;
      logic [7:0]    lim;
      logic [7:0]    qpfx;
      logic [127:0]  qaddr;
      bit            listed;
      bit            a_hit;
      bit            p_hit;
      int            best_a;
      int            best_p;
      int            diff;
      int            width;
      res    = '{ST_OK, 24'd0, 8'd0, 16'd0};
      lim    = it.is_ipv6 ? V6_MAX_PFX : V4_MAX_PFX;
      qpfx   = (it.pfx > lim) ? lim : it.pfx;
      qaddr  = it.is_ipv6 ? {it.addr_hi, it.addr_lo} : {it.addr_lo[31:0], 96'd0};
      a_hit  = 1'b0;
      p_hit  = 1'b0;
      best_a = 0;
      best_p = 0;
      case (it.opcode)
         OP_CLEAR: begin
            addr_used  = 0;
            port_used  = 0;
            proto_used = 0;
         end
         OP_ADD_ADDR: begin
            if (addr_used >= ADDR_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               addr_rules[addr_used] = '{is_ipv6: it.is_ipv6, prefix: qpfx, addr: qaddr};
               addr_used++;
            end
         end
         OP_ADD_PORT: begin
            if (port_used >= PORT_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               port_rules[port_used] = '{low: it.port_first, high: it.port_last};
               port_used++;
            end
         end
         OP_ADD_PROTO: begin
            if (proto_used >= PROTO_DEPTH) begin
               res.status = ST_FULL;
            end else begin
               proto_rules[proto_used] = it.proto;
               proto_used++;
            end
         end
         OP_QUERY: begin
            listed = (it.proto == 8'd0);
            for (int i = 0; i < proto_used; i++)
               if (proto_rules[i] == it.proto) listed = 1'b1;
            // best address hit: smallest prefix difference
            for (int i = 0; i < addr_used; i++) begin
               if (addr_rules[i].is_ipv6 == it.is_ipv6 && qpfx >= addr_rules[i].prefix &&
                   ((qaddr ^ addr_rules[i].addr) & prefix_mask(addr_rules[i].prefix)) == '0)
               begin
                  diff = int'(qpfx) - int'(addr_rules[i].prefix);
                  if (!a_hit || diff < best_a) begin
                     best_a = diff;
                     a_hit  = 1'b1;
                  end
               end
            end
            // narrowest port range holding the port
            for (int i = 0; i < port_used; i++) begin
               if (port_rules[i].low <= it.port_first && it.port_first <= port_rules[i].high)
               begin
                  width = int'(port_rules[i].high) - int'(port_rules[i].low);
                  if (!p_hit || width < best_p) begin
                     best_p = width;
                     p_hit  = 1'b1;
                  end
               end
            end
            if (listed && a_hit && p_hit) begin
               res.addr_score = best_a[7:0];
               res.port_score = best_p[15:0];
               res.combined   = {best_a[7:0], best_p[15:0]};
            end else begin
               res.status = ST_NOMATCH;
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // one transfer on the request side, with an occasional gap ahead of it
   task automatic send_item(input logic [2:0] op, input logic v6, input logic [63:0] hi,
                            input logic [63:0] lo, input logic [7:0] pfx,
                            input logic [15:0] pfirst, input logic [15:0] plast,
                            input logic [7:0] proto);
      rule_item_type    it;
      match_result_type res;
      it = '{op, v6, hi, lo, pfx, pfirst, plast, proto};
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {proto, plast, pfirst, pfx, lo, hi};
      req_tuser  <= {v6, op};
      do @(posedge clock); while (!req_tready);
      res = predict_match(it);
      pending_results.push_back(res);
      items_sent++;
      if (res.status == ST_FULL) full_inserts++;
      if (op == OP_QUERY && res.status == ST_OK) queries_hit++;
      if (op == OP_QUERY && res.status == ST_NOMATCH) queries_miss++;
   endtask

   // hold the request side until every result is back
   task automatic drain_results(input int settle);
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      if (error_count < PRINT_CAP)
         $display("mismatch at %0t: %s got 0x%0h want 0x%0h", $realtime, what, got, want);
      error_count++;
   endtask

   task automatic check_result(input logic [RSP_DATA_W-1:0] data,
                               input logic [RSP_USER_W-1:0] user);
      match_result_type want;
      if (pending_results.size() == 0) begin
         report_mismatch("result with nothing pending", 64'(data), 64'd0);
         return;
      end
      want = pending_results.pop_front();
      if (user[1:0] !== want.status)
         report_mismatch("status", 64'(user), 64'(want.status));
      if (data[23:0] !== want.combined)
         report_mismatch("combined_score", 64'(data[23:0]), 64'(want.combined));
      if (data[31:24] !== want.addr_score)
         report_mismatch("address_score", 64'(data[31:24]), 64'(want.addr_score));
      if (data[47:32] !== want.port_score)
         report_mismatch("port_score", 64'(data[47:32]), 64'(want.port_score));
   endtask

   // result side: check every transfer
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_result(rsp_tdata, rsp_tuser);
   end

   // result side backpressure in random bursts while gaps are on
   always @(posedge clock) begin
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (gaps_on && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // random address range, prefix sometimes past the family limit
   task automatic send_addr_rule();
      logic       v6;
      logic [7:0] pfx;
      v6  = 1'($urandom_range(0, 1));
      pfx = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                        : 8'($urandom_range(0, v6 ? 128 : 32));
      send_item(OP_ADD_ADDR, v6, {$urandom, $urandom}, {$urandom, $urandom}, pfx,
                rand_half(), rand_half(), rand_byte());
   endtask

   // random port range: extremes, narrow, or inverted
   task automatic send_port_rule();
      int lo_port;
      int hi_port;
      int pick;
      pick    = $urandom_range(0, 9);
      lo_port = $urandom_range(0, 65535);
      hi_port = lo_port + $urandom_range(0, 2000);
      if (hi_port > 65535) hi_port = 65535;
      if (pick == 0) begin
         lo_port = 0;
         hi_port = 65535;
      end else if (pick == 1) begin
         hi_port = lo_port;
      end
      if (pick == 2 && lo_port != hi_port)
         send_item(OP_ADD_PORT, rand_flag(), {$urandom, $urandom}, {$urandom, $urandom},
                   rand_byte(), 16'(hi_port), 16'(lo_port), rand_byte());
      else
         send_item(OP_ADD_PORT, rand_flag(), {$urandom, $urandom}, {$urandom, $urandom},
                   rand_byte(), 16'(lo_port), 16'(hi_port), rand_byte());
   endtask

   task automatic send_proto_rule();
      send_item(OP_ADD_PROTO, rand_flag(), {$urandom, $urandom}, {$urandom, $urandom},
                rand_byte(), rand_half(), rand_half(), rand_byte());
   endtask

   // query aimed mostly at stored ranges and ports
   task automatic send_probe();
      addr_entry_type rule;
      logic [127:0]   qaddr;
      logic [127:0]   mask;
      logic           v6;
      logic [7:0]     pfx;
      logic [15:0]    port;
      logic [7:0]     proto;
      logic [63:0]    hi;
      logic [63:0]    lo;
      int             idx;
      v6    = 1'($urandom_range(0, 1));
      qaddr = {$urandom, $urandom, $urandom, $urandom};
      pfx   = 8'($urandom_range(0, 255));
      if (addr_used > 0 && $urandom_range(0, 4) != 0) begin
         rule  = addr_rules[$urandom_range(0, addr_used - 1)];
         v6    = rule.is_ipv6;
         mask  = prefix_mask(rule.prefix);
         qaddr = (rule.addr & mask) | (qaddr & ~mask);
         if (rule.prefix > 0 && $urandom_range(0, 9) == 0)
            qaddr[128 - $urandom_range(1, rule.prefix)] ^= 1'b1;
         if ($urandom_range(0, 9) != 0)
            pfx = 8'($urandom_range(rule.prefix, v6 ? 128 : 32));
      end
      hi = v6 ? qaddr[127:64] : {$urandom, $urandom};
      lo = v6 ? qaddr[63:0] : {32'($urandom), qaddr[127:96]};
      port = rand_half();
      if (port_used > 0 && $urandom_range(0, 4) != 0) begin
         idx = $urandom_range(0, port_used - 1);
         if (port_rules[idx].low <= port_rules[idx].high)
            port = 16'($urandom_range(port_rules[idx].low, port_rules[idx].high));
      end
      case ($urandom_range(0, 4))
         0, 1: proto = 8'd0;
         2, 3: proto = (proto_used > 0) ? proto_rules[$urandom_range(0, proto_used - 1)]
                                        : rand_byte();
         default: proto = rand_byte();
      endcase
      send_item(OP_QUERY, v6, hi, lo, pfx, port, rand_half(), proto);
   endtask

   // queries against empty tables and the no-op opcodes
   task automatic test_empty_tables();
      send_item(OP_QUERY, 1'b0, 64'd0, 64'h0a00_0001, 8'd32, 16'd80, 16'd0, 8'd0);
      send_item(OP_SPARE_A, 1'b1, '1, '1, 8'hff, 16'hffff, 16'hffff, 8'hff);
      send_item(OP_SPARE_B, 1'b0, 64'd0, 64'd0, 8'd0, 16'd0, 16'd0, 8'd0);
      send_item(OP_SPARE_C, 1'b1, {$urandom, $urandom}, {$urandom, $urandom}, rand_byte(),
                rand_half(), rand_half(), rand_byte());
   endtask

   // IPv4 ranges: /0, /8, /16, clamped prefix, junk in the unused upper bits
   task automatic test_ipv4_rules();
      send_item(OP_ADD_ADDR, 1'b0, '1, 64'hffff_ffff_0a00_0000, 8'd8, 16'd0, 16'd0, 8'd0);
      send_item(OP_ADD_ADDR, 1'b0, 64'd0, 64'h0000_0000_0a01_0000, 8'd16, 16'd0, 16'd0, 8'd0);
      send_item(OP_ADD_ADDR, 1'b0, 64'd0, 64'd0, 8'd0, 16'd0, 16'd0, 8'd0);
      send_item(OP_ADD_ADDR, 1'b0, 64'd0, 64'h0000_0000_c0a8_0101, 8'd200, 16'd0, 16'd0, 8'd0);
      send_item(OP_ADD_PORT, 1'b0, 64'd0, 64'd0, 8'd0, 16'd0, 16'hffff, 8'd0);
      send_item(OP_ADD_PORT, 1'b0, 64'd0, 64'd0, 8'd0, 16'd80, 16'd80, 8'd0);
      send_item(OP_ADD_PORT, 1'b0, 64'd0, 64'd0, 8'd0, 16'd500, 16'd100, 8'd0);
      send_item(OP_ADD_PROTO, 1'b0, 64'd0, 64'd0, 8'd0, 16'd0, 16'd0, 8'd6);
      send_item(OP_QUERY, 1'b0, '1, 64'hdead_beef_0a01_0203, 8'd32, 16'd80, 16'd0, 8'd6);
      send_item(OP_QUERY, 1'b0, 64'd0, 64'h0000_0000_c0a8_0101, 8'd255, 16'd200, 16'd0, 8'd0);
      send_item(OP_QUERY, 1'b0, 64'd0, 64'h0000_0000_0a01_0203, 8'd32, 16'd80, 16'd0, 8'd17);
      send_item(OP_QUERY, 1'b0, 64'd0, 64'h0000_0000_0a01_0203, 8'd4, 16'hffff, 16'd0, 8'd0);
   endtask

   // IPv6 ranges across the 64-bit word boundary, full and clamped prefixes
   task automatic test_ipv6_rules();
      send_item(OP_ADD_ADDR, 1'b1, 64'h2001_0db8_0000_0000, 64'd0, 8'd32, 16'd0, 16'd0, 8'd0);
      send_item(OP_ADD_ADDR, 1'b1, '1, '1, 8'd128, 16'd0, 16'd0, 8'd0);
      send_item(OP_ADD_ADDR, 1'b1, 64'd0, 64'd1, 8'd255, 16'd0, 16'd0, 8'd0);
      send_item(OP_ADD_ADDR, 1'b1, '1, 64'h8000_0000_0000_0000, 8'd65, 16'd0, 16'd0, 8'd0);
      send_item(OP_QUERY, 1'b1, 64'h2001_0db8_0000_0000, 64'habcd, 8'd64, 16'd0, 16'd0, 8'd6);
      send_item(OP_QUERY, 1'b1, '1, '1, 8'd128, 16'hffff, 16'd0, 8'd0);
      send_item(OP_QUERY, 1'b1, 64'd0, 64'd1, 8'd200, 16'd80, 16'd0, 8'd0);
      send_item(OP_QUERY, 1'b1, '1, 64'hc000_0000_0000_0000, 8'd70, 16'd300, 16'd0, 8'd0);
      send_item(OP_QUERY, 1'b1, 64'd0, 64'd0, 8'd0, 16'd80, 16'd0, 8'd0);
   endtask

   task automatic test_clear();
      send_item(OP_CLEAR, 1'b1, '1, '1, 8'hff, 16'hffff, 16'hffff, 8'hff);
      send_item(OP_QUERY, 1'b1, '1, '1, 8'd128, 16'd80, 16'd0, 8'd0);
   endtask

   // fill every table past its depth, then probe at full scan length
   task automatic test_table_full();
      send_item(OP_CLEAR, 1'b0, 64'd0, 64'd0, 8'd0, 16'd0, 16'd0, 8'd0);
      repeat (ADDR_DEPTH + 2) send_addr_rule();
      repeat (PORT_DEPTH + 2) send_port_rule();
      repeat (PROTO_DEPTH + 2) send_proto_rule();
      repeat (20) send_probe();
      // let the block empty out before going on
      drain_results(0);
   endtask

   // load a rule set (mostly small, mostly after a clear), then probe it; repeated
   task automatic test_random_sets();
      int n_rules;
      int target;
      target = items_sent + RANDOM_ITEMS;
      while (items_sent < target) begin
         if (target - items_sent <= QUIET_TAIL) gaps_on = 1'b0;
         else gaps_on = ($urandom_range(0, 3) != 0);
         if ($urandom_range(0, 4) != 0)
            send_item(OP_CLEAR, rand_flag(), {$urandom, $urandom}, {$urandom, $urandom},
                      rand_byte(), rand_half(), rand_half(), rand_byte());
         n_rules = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 10);
         repeat (n_rules) begin
            case ($urandom_range(0, 4))
               0, 1: send_addr_rule();
               2, 3: send_port_rule();
               default: send_proto_rule();
            endcase
         end
         repeat ($urandom_range(4, 16)) begin
            if ($urandom_range(0, 19) == 0)
               send_item(3'($urandom_range(OP_SPARE_A, OP_SPARE_C)), rand_flag(),
                         {$urandom, $urandom}, {$urandom, $urandom}, rand_byte(),
                         rand_half(), rand_half(), rand_byte());
            else
               send_probe();
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_tables();
      test_ipv4_rules();
      test_ipv6_rules();
      test_clear();
      test_table_full();
      test_random_sets();
      drain_results(SETTLE_CYCLES);
      $display("ran %0d items over %0d cycles: %0d matching queries, %0d non-matching",
               items_sent, cycle_count, queries_hit, queries_miss);
      $display("%0d inserts hit a full table, %0d mismatches", full_inserts, error_count);
      if (error_count == 0) begin
         $display("PASS intercept_rule_matcher");
      end else begin
         $display("FAIL intercept_rule_matcher");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+sv
sv/irm_pkg.sv
sv/intercept_rule_matcher.sv
tb/intercept_rule_matcher_tb.sv
